>>> hw/rtl/crc8cfp_pkg.sv
// Package for the sync-header CRC-8 / checksum frame parser: types, constants, helpers.
package crc8cfp_pkg;

    localparam int MAX_FRAME_BYTES = 1024;
    localparam int HEADER_BYTES    = 7;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    localparam int CNT_W  = $clog2(MAX_FRAME_BYTES + 1);
    localparam int SUM_W  = LEN_W + 1;
    localparam int CMP_W  = LEN_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;
    localparam logic [BYTE_W-1:0] VERSION_RST     = 8'h01;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_FIRST  = 2'd0,
        CFG_SYNC_SECOND = 2'd1,
        CFG_VERSION     = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        PH_SYNC1  = 4'd0,
        PH_SYNC2  = 4'd1,
        PH_LEN1   = 4'd2,
        PH_LEN2   = 4'd3,
        PH_VER    = 4'd4,
        PH_RECV   = 4'd5,
        PH_CRC    = 4'd6,
        PH_SENDER = 4'd7,
        PH_ATTR   = 4'd8,
        PH_DATA   = 4'd9,
        PH_CK1    = 4'd10,
        PH_CK2    = 4'd11
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] version;
    } t_cfg;

    typedef struct packed {
        logic              data_valid;
        logic [BYTE_W-1:0] data_byte;
        logic              frame_end;
        logic              frame_good;
        logic [BYTE_W-1:0] receiver_id;
        logic [BYTE_W-1:0] sender_id;
        logic [BYTE_W-1:0] attribute;
        logic [LEN_W-1:0]  body_length;
    } t_result;

    // CRC-8, MSB first, one byte
    function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] v;
        v = crc ^ b;
        for (int i = 0; i < BYTE_W; i++) begin
            if (v[BYTE_W-1]) begin
                v = (v << 1) ^ CRC_POLY;
            end else begin
                v = v << 1;
            end
        end
        return v;
    endfunction

    // one's-complement add with end-around carry fold
    function automatic logic [SUM_W-1:0] sum_fold(input logic [SUM_W-1:0] acc,
                                                  input logic [LEN_W-1:0] v);
        logic [SUM_W:0] s;
        s = {1'b0, acc} + {2'b00, v};
        return SUM_W'({2'b00, s[LEN_W-1:0]} + {{(SUM_W-1){1'b0}}, s[SUM_W:LEN_W]});
    endfunction

endpackage

>>> hw/rtl/crc8cfp_parser.sv
// Frame parser state machine with header CRC and body checksum datapath.
module crc8cfp_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req,
    input  logic [7:0]                    i_rx_byte,
    input  crc8cfp_pkg::t_cfg             i_cfg,
    output crc8cfp_pkg::t_result          o_result
);
    import crc8cfp_pkg::*;

    t_phase             r_phase, n_phase;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [BYTE_W-1:0]  r_crc, n_crc;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [BYTE_W-1:0]  r_hi, n_hi;
    logic               r_odd, n_odd;
    logic [BYTE_W-1:0]  r_cklo, n_cklo;
    logic [BYTE_W-1:0]  r_recv, n_recv;
    logic [BYTE_W-1:0]  r_send, n_send;
    logic [BYTE_W-1:0]  r_attr, n_attr;

    logic               body_ovf;
    logic               body_last;
    logic [CNT_W-1:0]   cnt_inc;
    logic [BYTE_W-1:0]  crc_next;
    logic [SUM_W-1:0]   sum_pair;
    logic [SUM_W-1:0]   sum_final;
    logic [LEN_W-1:0]   total;
    t_result            res;

    assign cnt_inc   = r_cnt + CNT_W'(1);
    assign body_ovf  = (r_cnt >= CNT_W'(MAX_FRAME_BYTES));
    assign body_last = (CMP_W'(cnt_inc) == ({1'b0, r_len} + CMP_W'(HEADER_BYTES)));
    assign crc_next  = crc8_step(r_crc, i_rx_byte);
    assign sum_pair  = sum_fold(r_sum, {r_hi, i_rx_byte});
    assign sum_final = r_odd ? sum_fold(r_sum, {{BYTE_W{1'b0}}, r_hi}) : r_sum;
    assign total     = ~sum_final[LEN_W-1:0];

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_SYNC1:  n_phase = (i_rx_byte == i_cfg.sync_first) ? PH_SYNC2 : PH_SYNC1;
            PH_SYNC2:  n_phase = (i_rx_byte == i_cfg.sync_second) ? PH_LEN1 : PH_SYNC1;
            PH_LEN1:   n_phase = PH_LEN2;
            PH_LEN2:   n_phase = PH_VER;
            PH_VER:    n_phase = (i_rx_byte == i_cfg.version) ? PH_RECV : PH_SYNC1;
            PH_RECV:   n_phase = PH_CRC;
            PH_CRC:    n_phase = (i_rx_byte == r_crc) ? PH_SENDER : PH_SYNC1;
            PH_SENDER: n_phase = body_ovf ? PH_SYNC1 : (body_last ? PH_CK1 : PH_ATTR);
            PH_ATTR:   n_phase = body_ovf ? PH_SYNC1 : (body_last ? PH_CK1 : PH_DATA);
            PH_DATA:   n_phase = body_ovf ? PH_SYNC1 : (body_last ? PH_CK1 : PH_DATA);
            PH_CK1:    n_phase = PH_CK2;
            PH_CK2:    n_phase = PH_SYNC1;
            default:   n_phase = PH_SYNC1;
        endcase
    end

    // datapath and result
    always_comb begin
        n_len  = r_len;
        n_cnt  = r_cnt;
        n_crc  = r_crc;
        n_sum  = r_sum;
        n_hi   = r_hi;
        n_odd  = r_odd;
        n_cklo = r_cklo;
        n_recv = r_recv;
        n_send = r_send;
        n_attr = r_attr;
        res.data_valid = 1'b0;
        res.data_byte  = '0;
        res.frame_end  = 1'b0;
        res.frame_good = 1'b0;
        unique case (r_phase)
            PH_SYNC1: begin
                if (i_rx_byte == i_cfg.sync_first) begin
                    n_crc = crc8_step('0, i_rx_byte);
                    n_cnt = CNT_W'(1);
                    n_sum = '0;
                    n_hi  = '0;
                    n_odd = 1'b0;
                end
            end
            PH_SYNC2, PH_VER: begin
                if ((r_phase == PH_SYNC2 && i_rx_byte == i_cfg.sync_second) ||
                    (r_phase == PH_VER && i_rx_byte == i_cfg.version)) begin
                    n_crc = crc_next;
                    n_cnt = cnt_inc;
                end
            end
            PH_LEN1, PH_LEN2, PH_RECV: begin
                n_crc = crc_next;
                n_cnt = cnt_inc;
                if (r_phase == PH_LEN1) begin
                    n_len = {{(LEN_W-BYTE_W){1'b0}}, i_rx_byte};
                end else if (r_phase == PH_LEN2) begin
                    n_len = {i_rx_byte, r_len[BYTE_W-1:0]};
                end else begin
                    n_recv = i_rx_byte;
                end
            end
            PH_CRC: begin
                if (i_rx_byte == r_crc) begin
                    n_cnt = cnt_inc;
                end
            end
            PH_SENDER, PH_ATTR, PH_DATA: begin
                if (body_ovf) begin
                    res.frame_end = 1'b1;
                end else begin
                    n_cnt = cnt_inc;
                    if (r_odd) begin
                        n_sum = sum_pair;
                        n_odd = 1'b0;
                    end else begin
                        n_hi  = i_rx_byte;
                        n_odd = 1'b1;
                    end
                    if (r_phase == PH_SENDER) begin
                        n_send = i_rx_byte;
                    end else if (r_phase == PH_ATTR) begin
                        n_attr = i_rx_byte;
                    end else begin
                        res.data_valid = 1'b1;
                        res.data_byte  = i_rx_byte;
                    end
                end
            end
            PH_CK1: begin
                n_cklo = i_rx_byte;
            end
            PH_CK2: begin
                n_sum          = sum_final;
                res.frame_end  = 1'b1;
                res.frame_good = (total == {i_rx_byte, r_cklo});
            end
            default: begin
            end
        endcase
        res.receiver_id = n_recv;
        res.sender_id   = n_send;
        res.attribute   = n_attr;
        res.body_length = n_len;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_len   <= '0;
            r_cnt   <= '0;
            r_crc   <= '0;
            r_sum   <= '0;
            r_hi    <= '0;
            r_odd   <= 1'b0;
            r_cklo  <= '0;
            r_recv  <= '0;
            r_send  <= '0;
            r_attr  <= '0;
        end else if (i_req) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_crc   <= n_crc;
            r_sum   <= n_sum;
            r_hi    <= n_hi;
            r_odd   <= n_odd;
            r_cklo  <= n_cklo;
            r_recv  <= n_recv;
            r_send  <= n_send;
            r_attr  <= n_attr;
        end
    end

    a_data_stays_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req && r_phase == PH_DATA && res.data_valid |=>
            r_phase == PH_DATA || r_phase == PH_CK1)
        else $error("data byte did not leave parser in data or checksum phase");

    a_ck2_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req && r_phase == PH_CK2 |-> res.frame_end ##1 r_phase == PH_SYNC1)
        else $error("checksum close did not end frame and return to hunt");

    a_good_needs_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.frame_good |-> res.frame_end && !res.data_valid)
        else $error("frame_good without frame_end");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req && body_ovf && (r_phase == PH_DATA || r_phase == PH_ATTR) |=>
            r_phase == PH_SYNC1 && $stable(r_cnt))
        else $error("overflow abort did not return to hunt");

endmodule

>>> hw/rtl/crc8cfp_out_buf.sv
// Two-entry output buffer decoupling result stall from input stall.
module crc8cfp_out_buf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  crc8cfp_pkg::t_result  i_data,
    output logic                  o_full,
    output logic                  o_valid,
    input  logic                  i_stall,
    output crc8cfp_pkg::t_result  o_data
);
    import crc8cfp_pkg::*;

    logic [1:0] r_cnt, n_cnt;
    t_result    r_e0;
    t_result    r_e1;
    logic       pop;

    assign pop     = (r_cnt != 2'd0) && !i_stall;
    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_e0;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cnt == 2'd2 && pop) begin
            r_e0 <= r_e1;
        end else if (i_push && (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop))) begin
            r_e0 <= i_data;
        end
        if (i_push && r_cnt == 2'd1 && !pop) begin
            r_e1 <= i_data;
        end
    end

endmodule

>>> hw/rtl/crc8_checksum_frame_parser_unit.sv
// Top level of the sync-header CRC-8 / checksum frame parser.
// Usage:
//   Input channel: i_valid / o_stall carry one received byte (i_rx_byte) per
//   request. Output channel: o_valid / i_stall carry one result per input
//   request: data byte strobe, frame end and good flags, and the current
//   header and body identifiers and body length.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 first sync byte, 1 second sync byte, 2 version); other indexes are
//   ignored. Write only while the block is idle.
//   Output: each result is registered in the output buffer.
//   Throughput: one byte per cycle while o_stall is low; all parsing, CRC-8
//   and checksum update for a byte happen in one pass of logic between
//   parser state and the output buffer.
//   Receiver stall: a two-entry output buffer absorbs results; o_stall rises
//   only while both entries are held.
//   Reset (synchronous, active low): parser hunts the first sync byte, all
//   captured fields read zero, the buffer is empty and the configuration
//   returns to 0xAA, 0x55, 0x01.
module crc8_checksum_frame_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_data_valid,
    output logic [7:0]  o_data_byte,
    output logic        o_frame_end,
    output logic        o_frame_good,
    output logic [7:0]  o_receiver_id,
    output logic [7:0]  o_sender_id,
    output logic [7:0]  o_attribute,
    output logic [15:0] o_body_length,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    import crc8cfp_pkg::*;

    t_cfg    r_cfg;
    t_result parse_res;
    t_result out_res;
    logic    buf_full;
    logic    req;

    assign o_stall = buf_full;
    assign req     = i_valid && !buf_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= SYNC_FIRST_RST;
            r_cfg.sync_second <= SYNC_SECOND_RST;
            r_cfg.version     <= VERSION_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SYNC_FIRST:  r_cfg.sync_first  <= i_cfg_data;
                CFG_SYNC_SECOND: r_cfg.sync_second <= i_cfg_data;
                CFG_VERSION:     r_cfg.version     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    crc8cfp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (r_cfg),
        .o_result  (parse_res)
    );

    crc8cfp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (req),
        .i_data  (parse_res),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (out_res)
    );

    assign o_data_valid  = out_res.data_valid;
    assign o_data_byte   = out_res.data_byte;
    assign o_frame_end   = out_res.frame_end;
    assign o_frame_good  = out_res.frame_good;
    assign o_receiver_id = out_res.receiver_id;
    assign o_sender_id   = out_res.sender_id;
    assign o_attribute   = out_res.attribute;
    assign o_body_length = out_res.body_length;

endmodule
